@@ rtl/pressure_temperature_compensation_core_defines.svh @@
// Assertion macros for the compensation core.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_CORE_DEFINES_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PTC_ASSERT(lbl, prop) lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
    prop) else $error("ptc check failed");
`define PTC_ASSERT_ALWAYS(lbl, prop) lbl: assert property (@(posedge i_clk) prop) \
    else $error("ptc check failed");
`else
`define PTC_ASSERT(lbl, prop)
`define PTC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

@@ rtl/ptc_pkg.sv @@
// Shared types, constants and helpers of the compensation core.
// No dependencies.
package ptc_pkg;
    localparam logic [63:0] FINE_OFFSET = 64'd128000;
    localparam logic [20:0] ADC_FULL    = 21'd1048576;
    localparam logic [63:0] DIV_SCALE   = 64'd3125;
    localparam logic [31:0] ROUND_HALF  = 32'd128;
    localparam logic [63:0] ONE_Q47     = 64'h0000_8000_0000_0000;

    localparam logic [1:0] REG_TEMP    = 2'd0;
    localparam logic [1:0] REG_PLOW    = 2'd1;
    localparam logic [1:0] REG_PHIGH   = 2'd2;
    localparam logic [1:0] REG_PNINE   = 2'd3;

    localparam logic OP_TEMP  = 1'b0;
    localparam logic OP_PRESS = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE, S_T1, S_T2, S_T3, S_T4,
        S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7,
        S_DIV, S_P8, S_P9, S_P10, S_PF, S_DONE
    } t_state;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
        logic [6:0]  len;
    } t_mul_req;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } t_div_req;

    function automatic logic [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] sx32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction
endpackage

@@ rtl/ptc_mul.sv @@
// Bit-serial shift-add multiplier, low 64 bits of a times signed len-bit b.
// Depends on ptc_pkg.
module ptc_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ptc_pkg::t_mul_req i_req,
    output logic              o_done,
    output logic [63:0]       o_prod
);
    import ptc_pkg::*;

    logic [63:0] r_a, r_b, r_acc;
    logic [6:0]  r_cnt;
    logic        r_busy, r_done;
    logic [63:0] w_term;
    logic        w_last;

    assign w_last = (r_cnt == 7'd1);

    always_comb begin
        if (!r_b[0]) begin
            w_term = '0;
        end else if (w_last) begin
            w_term = ~r_a + 64'd1;
        end else begin
            w_term = r_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.len;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_req.a;
            r_b   <= i_req.b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + w_term;
            r_a   <= {r_a[62:0], 1'b0};
            r_b   <= {1'b0, r_b[63:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

@@ rtl/ptc_div.sv @@
// Bit-serial restoring divider, unsigned 64 by 64 bits, one quotient bit a cycle.
// Depends on ptc_pkg.
module ptc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ptc_pkg::t_div_req i_req,
    output logic              o_done,
    output logic [63:0]       o_quo
);
    import ptc_pkg::*;

    logic [63:0] r_rem, r_quo, r_den;
    logic [6:0]  r_cnt;
    logic        r_busy, r_done;
    logic [64:0] w_shift, w_diff;

    assign w_shift = {r_rem, r_quo[63]};
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            if (!w_diff[64]) begin
                r_rem <= w_diff[63:0];
                r_quo <= {r_quo[62:0], 1'b1};
            end else begin
                r_rem <= w_shift[63:0];
                r_quo <= {r_quo[62:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

@@ rtl/pressure_temperature_compensation_core.sv @@
// Barometric sensor integer compensation: temperature and pressure paths.
// Depends on ptc_pkg, ptc_mul, ptc_div and the core defines header.
//
// One word in gives one word out. A temperature word takes three
// 16/18-bit serial products. A pressure word takes ten serial products
// and one pass through the serial divider. A zero divisor ends the word
// after the sixth product. Every product runs on the single shift-add
// multiplier and the quotient on the one-bit-a-cycle divider. Words are
// processed one at a time; the next word is taken once the result sits in
// the output register, and s_axis_tready is low while a word is in work.
`include "pressure_temperature_compensation_core_defines.svh"
module pressure_temperature_compensation_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [19:0] adc_value, zero pad
    input  logic        s_axis_tuser,   // [0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [31:0] temperature_centi,
                                        // [63:32] pressure_q24_8,
                                        // [64] zero_divisor, zero pad
    output logic        m_axis_tuser    // [0] kind
);
    import ptc_pkg::*;

    t_state      r_state, n_state;
    logic        r_issue;
    logic [47:0] r_tc;
    logic [63:0] r_pl, r_ph;
    logic [15:0] r_p9;
    logic [31:0] r_fine;
    logic [19:0] r_adc;
    logic        r_kind;
    logic [63:0] r_x, r_xx, r_y, r_v, r_num, r_q, r_w;
    logic [31:0] r_ta, r_tb;
    logic [31:0] r_res_t, r_res_p;
    logic        r_res_z, r_neg;
    logic        r_mv;
    logic [71:0] r_mdata;
    logic        r_muser;

    t_mul_req    w_mreq;
    t_div_req    w_dreq;
    logic        w_mul_done, w_div_done, w_is_mul;
    logic [63:0] w_prod, w_quo, w_h;
    logic [31:0] w_t32, w_fine_new;
    logic        w_accept, w_out_free;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_mv || m_axis_tready;
    assign w_h           = $signed(r_q) >>> 13;
    assign w_t32         = $signed(w_prod[31:0]) >>> 14;
    assign w_fine_new    = r_ta + w_t32;

    ptc_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_mreq),
        .o_done (w_mul_done),
        .o_prod (w_prod)
    );

    ptc_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_dreq),
        .o_done (w_div_done),
        .o_quo  (w_quo)
    );

    always_comb begin
        w_is_mul   = 1'b1;
        w_mreq.a   = r_x;
        w_mreq.b   = r_x;
        w_mreq.len = 7'd64;
        unique case (r_state)
            S_T1: begin
                w_mreq.a   = {47'd0, r_adc[19:3]} - {47'd0, r_tc[15:0], 1'b0};
                w_mreq.b   = sx16(r_tc[31:16]);
                w_mreq.len = 7'd16;
            end
            S_T2: begin
                w_mreq.a   = {48'd0, r_adc[19:4]} - {48'd0, r_tc[15:0]};
                w_mreq.b   = w_mreq.a;
                w_mreq.len = 7'd18;
            end
            S_T3: begin
                w_mreq.a   = sx32(r_tb);
                w_mreq.b   = sx16(r_tc[47:32]);
                w_mreq.len = 7'd16;
            end
            S_P1: begin
                w_mreq.len = 7'd34;
            end
            S_P2: begin
                w_mreq.a   = r_xx;
                w_mreq.b   = sx16(r_ph[31:16]);
                w_mreq.len = 7'd16;
            end
            S_P3: begin
                w_mreq.b   = sx16(r_ph[15:0]);
                w_mreq.len = 7'd16;
            end
            S_P4: begin
                w_mreq.a   = r_xx;
                w_mreq.b   = sx16(r_pl[47:32]);
                w_mreq.len = 7'd16;
            end
            S_P5: begin
                w_mreq.b   = sx16(r_pl[31:16]);
                w_mreq.len = 7'd16;
            end
            S_P6: begin
                w_mreq.a   = ONE_Q47 + r_v;
                w_mreq.b   = {48'd0, r_pl[15:0]};
                w_mreq.len = 7'd17;
            end
            S_P7: begin
                w_mreq.a   = {12'd0, ADC_FULL - {1'b0, r_adc}, 31'd0} - r_y;
                w_mreq.b   = DIV_SCALE;
                w_mreq.len = 7'd13;
            end
            S_P8: begin
                w_mreq.a   = w_h;
                w_mreq.b   = sx16(r_p9);
                w_mreq.len = 7'd16;
            end
            S_P9: begin
                w_mreq.a   = r_w;
                w_mreq.b   = w_h;
            end
            S_P10: begin
                w_mreq.a   = r_q;
                w_mreq.b   = sx16(r_ph[63:48]);
                w_mreq.len = 7'd16;
            end
            default: begin
                w_is_mul = 1'b0;
            end
        endcase
        w_mreq.start = r_issue && w_is_mul;
        w_dreq.start    = r_issue && (r_state == S_DIV);
        w_dreq.dividend = r_num[63] ? (~r_num + 64'd1) : r_num;
        w_dreq.divisor  = r_v[63] ? (~r_v + 64'd1) : r_v;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept) n_state = (s_axis_tuser == OP_TEMP) ? S_T1 : S_P1;
            S_T1:    if (w_mul_done) n_state = S_T2;
            S_T2:    if (w_mul_done) n_state = S_T3;
            S_T3:    if (w_mul_done) n_state = S_T4;
            S_T4:    n_state = S_DONE;
            S_P1:    if (w_mul_done) n_state = S_P2;
            S_P2:    if (w_mul_done) n_state = S_P3;
            S_P3:    if (w_mul_done) n_state = S_P4;
            S_P4:    if (w_mul_done) n_state = S_P5;
            S_P5:    if (w_mul_done) n_state = S_P6;
            S_P6:    if (w_mul_done) n_state = (w_prod[63:33] == '0) ? S_DONE : S_P7;
            S_P7:    if (w_mul_done) n_state = S_DIV;
            S_DIV:   if (w_div_done) n_state = S_P8;
            S_P8:    if (w_mul_done) n_state = S_P9;
            S_P9:    if (w_mul_done) n_state = S_P10;
            S_P10:   if (w_mul_done) n_state = S_PF;
            S_PF:    n_state = S_DONE;
            S_DONE:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_issue <= 1'b0;
            r_mv    <= 1'b0;
            r_tc    <= '0;
            r_pl    <= '0;
            r_ph    <= '0;
            r_p9    <= '0;
            r_fine  <= '0;
        end else begin
            r_state <= n_state;
            r_issue <= (n_state != r_state);
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_TEMP:  r_tc <= i_cfg_data[47:0];
                    REG_PLOW:  r_pl <= i_cfg_data;
                    REG_PHIGH: r_ph <= i_cfg_data;
                    REG_PNINE: r_p9 <= i_cfg_data[15:0];
                    default:   ;
                endcase
            end
            if (r_state == S_T3 && w_mul_done) begin
                r_fine <= w_fine_new;
            end
            if (r_state == S_DONE && w_out_free) begin
                r_mv <= 1'b1;
            end else if (m_axis_tready) begin
                r_mv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_adc  <= s_axis_tdata[19:0];
            r_kind <= s_axis_tuser;
            r_x    <= sx32(r_fine) - FINE_OFFSET;
        end
        unique case (r_state)
            S_T1: if (w_mul_done) r_ta <= $signed(w_prod[31:0]) >>> 11;
            S_T2: if (w_mul_done) r_tb <= $signed(w_prod[31:0]) >>> 12;
            S_T4: begin
                r_res_t <= $signed((r_fine << 2) + r_fine + ROUND_HALF) >>> 8;
                r_res_p <= '0;
                r_res_z <= 1'b0;
            end
            S_P1: if (w_mul_done) r_xx <= w_prod;
            S_P2: if (w_mul_done) r_y <= w_prod;
            S_P3: if (w_mul_done) r_y <= r_y + {w_prod[46:0], 17'd0}
                                       + {{13{r_pl[63]}}, r_pl[63:48], 35'd0};
            S_P4: if (w_mul_done) r_v <= $signed(w_prod) >>> 8;
            S_P5: if (w_mul_done) r_v <= r_v + {w_prod[51:0], 12'd0};
            S_P6: if (w_mul_done) begin
                r_v     <= $signed(w_prod) >>> 33;
                r_res_t <= '0;
                r_res_p <= '0;
                r_res_z <= (w_prod[63:33] == '0);
            end
            S_P7: if (w_mul_done) begin
                r_num <= w_prod;
                r_neg <= w_prod[63] ^ r_v[63];
            end
            S_DIV: if (w_div_done) r_q <= r_neg ? (~w_quo + 64'd1) : w_quo;
            S_P8:  if (w_mul_done) r_w <= w_prod;
            S_P9:  if (w_mul_done) r_w <= $signed(w_prod) >>> 25;
            S_P10: if (w_mul_done) r_y <= $signed(w_prod) >>> 19;
            S_PF: begin
                r_res_p <= 32'(($signed(r_q + r_w + r_y) >>> 8)
                               + {{44{r_ph[47]}}, r_ph[47:32], 4'd0});
            end
            default: ;
        endcase
        if (r_state == S_DONE && w_out_free) begin
            r_mdata <= {7'd0, r_res_z, r_res_p, r_res_t};
            r_muser <= r_kind;
        end
    end

    assign m_axis_tvalid = r_mv;
    assign m_axis_tdata  = r_mdata;
    assign m_axis_tuser  = r_muser;

    `PTC_ASSERT(a_units_exclusive, !(w_mul_done && w_div_done))
    `PTC_ASSERT(a_accept_starts, w_accept |=> (r_state != S_IDLE))
    `PTC_ASSERT(a_div_in_state, w_div_done |-> (r_state == S_DIV))
endmodule
